[rtl/core/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg
// Shared widths, codes and controller/datapath interface types for the probe
// slot cache.
// ----------------------------------------------------------------------------
package psc_pkg;

   localparam int DEFAULT_ENTRIES = 16;
   localparam int ID_W            = 16;
   localparam int STAMP_W         = 32;
   localparam int SLOT_W          = 4;
   localparam int BUDGET_W        = 5;

   localparam logic [STAMP_W-1:0]  FRAME_MAX      = 32'hFFFF_FFFE;
   localparam logic [BUDGET_W-1:0] RENDER_CNT_MAX = 5'd31;
   localparam logic [BUDGET_W-1:0] BUDGET_RESET   = 5'd1;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_FRAME  = 1'b1;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } psc_cmd_type;

   typedef struct packed {
      logic req_frame;
      logic scan_last;
      logic out_free;
   } psc_sts_type;

endpackage

[rtl/core/psc_ctrl.sv]
// ----------------------------------------------------------------------------
// psc_ctrl
// Sequencer for the probe slot cache: accept, scan, drain, finish; a frame tick skips the scan and drain.
// ----------------------------------------------------------------------------
module psc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  psc_pkg::psc_sts_type sts,
   output psc_pkg::psc_cmd_type cmd
);
   import psc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign cmd.load   = accept;
   assign cmd.scan   = (state_ff == ST_SCAN);
   assign cmd.finish = (state_ff == ST_FINISH) && sts.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = sts.req_frame ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/psc_dpath.sv]
// ----------------------------------------------------------------------------
// psc_dpath
// Slot key and stamp memories, valid bits, scan compare, frame and render
// counters, and the result register.
// ----------------------------------------------------------------------------
module psc_dpath #(
   parameter int ENTRIES = psc_pkg::DEFAULT_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  psc_pkg::psc_cmd_type          cmd,
   output psc_pkg::psc_sts_type          sts,
   input  logic                          req_kind,
   input  logic [psc_pkg::ID_W-1:0]      req_probe_id,
   input  logic                          req_pending,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [psc_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic                          rsp_hit,
   output logic                          rsp_render_now,
   output logic                          rsp_pending_next,
   input  logic                          csr_wr_en,
   input  logic [psc_pkg::BUDGET_W-1:0]  csr_wr_data
);
   import psc_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   logic [ID_W-1:0]    key_mem [ENTRIES];
   logic [STAMP_W-1:0] stamp_mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   logic               kind_ff;
   logic [ID_W-1:0]    id_ff;
   logic               pend_ff;
   logic [IDX_W-1:0]   idx_ff;

   logic               cmp_en_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic               cmp_valid_ff;
   logic [ID_W-1:0]    cmp_key_ff;
   logic [STAMP_W-1:0] cmp_stamp_ff;

   logic               hit_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic               have_empty_ff;
   logic [IDX_W-1:0]   empty_idx_ff;
   logic               have_kick_ff;
   logic [IDX_W-1:0]   kick_idx_ff;
   logic [STAMP_W-1:0] kick_stamp_ff;

   logic [STAMP_W-1:0]  frame_ff;
   logic [BUDGET_W-1:0] renders_ff;
   logic [BUDGET_W-1:0] budget_ff;

   logic                rsp_valid_ff;
   logic [SLOT_W-1:0]   slot_out_ff;
   logic                hit_out_ff;
   logic                render_out_ff;
   logic                pend_out_ff;

   logic [IDX_W-1:0]        slot_sel;
   logic [IDX_W+SLOT_W-1:0] slot_ext;
   logic                    render;
   logic                    is_frame;
   logic                    out_free;

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign is_frame      = (kind_ff == KIND_FRAME);
   assign sts.req_frame = (req_kind == KIND_FRAME);
   assign sts.scan_last = (idx_ff == LAST_IDX);
   assign sts.out_free  = out_free;

   assign slot_sel = hit_ff ? hit_idx_ff : (have_empty_ff ? empty_idx_ff : kick_idx_ff);
   assign slot_ext = {{SLOT_W{1'b0}}, slot_sel};
   assign render   = pend_ff && (renders_ff < budget_ff);

   // latch item, advance scan address
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         id_ff   <= req_probe_id;
         pend_ff <= req_pending;
      end
      if (cmd.load) begin
         idx_ff <= '0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // memories: one read port for the scan, one write port at finish
   always_ff @(posedge clock) begin
      cmp_key_ff   <= key_mem[idx_ff];
      cmp_stamp_ff <= stamp_mem[idx_ff];
      cmp_valid_ff <= valid_ff[idx_ff];
      cmp_idx_ff   <= idx_ff;
      if (cmd.finish && !is_frame) begin
         stamp_mem[slot_sel] <= frame_ff;
         if (!hit_ff) begin
            key_mem[slot_sel] <= id_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         cmp_en_ff <= 1'b0;
      end else begin
         cmp_en_ff <= cmd.scan;
         if (cmd.finish && !is_frame) begin
            valid_ff[slot_sel] <= 1'b1;
         end
      end
   end

   // scan compare: first hit, first empty, oldest valid
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hit_ff        <= 1'b0;
         have_empty_ff <= 1'b0;
         have_kick_ff  <= 1'b0;
      end else if (cmp_en_ff && !hit_ff) begin
         if (cmp_valid_ff) begin
            if (cmp_key_ff == id_ff) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= cmp_idx_ff;
            end else if (!have_kick_ff || (cmp_stamp_ff < kick_stamp_ff)) begin
               have_kick_ff  <= 1'b1;
               kick_idx_ff   <= cmp_idx_ff;
               kick_stamp_ff <= cmp_stamp_ff;
            end
         end else if (!have_empty_ff) begin
            have_empty_ff <= 1'b1;
            empty_idx_ff  <= cmp_idx_ff;
         end
      end
   end

   // frame, render and budget counters
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff   <= '0;
         renders_ff <= '0;
         budget_ff  <= BUDGET_RESET;
      end else begin
         if (csr_wr_en) begin
            budget_ff <= csr_wr_data;
         end
         if (cmd.finish) begin
            if (is_frame) begin
               if (frame_ff != FRAME_MAX) begin
                  frame_ff <= frame_ff + 1'b1;
               end
               renders_ff <= '0;
            end else if (render && (renders_ff != RENDER_CNT_MAX)) begin
               renders_ff <= renders_ff + 1'b1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (is_frame) begin
            slot_out_ff   <= '0;
            hit_out_ff    <= 1'b0;
            render_out_ff <= 1'b0;
            pend_out_ff   <= 1'b0;
         end else begin
            slot_out_ff   <= slot_ext[SLOT_W-1:0];
            hit_out_ff    <= hit_ff;
            render_out_ff <= render;
            pend_out_ff   <= !hit_ff || (pend_ff && !render);
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_index   = slot_out_ff;
   assign rsp_hit          = hit_out_ff;
   assign rsp_render_now   = render_out_ff;
   assign rsp_pending_next = pend_out_ff;

endmodule

[rtl/core/probe_slot_cache_lru_core.sv]
// ----------------------------------------------------------------------------
// probe_slot_cache_lru_core
// Fully associative probe-to-slot table with frame-stamp LRU replacement and
// a per-frame render budget.
// ----------------------------------------------------------------------------
// A lookup scans the slot key and stamp memories one slot per cycle through
// a single registered read port, then drains the compare and writes the
// chosen slot and the result. A frame tick skips the scan and the drain and
// goes straight to the final step. A finished result sits in an output
// register; the next item is accepted once that result has moved into it,
// and a stalled output holds the block in its final step. The slot memories
// need no clearing pass after reset; only the valid bits are cleared.
// ----------------------------------------------------------------------------
module probe_slot_cache_lru_core #(
   parameter int ENTRIES = psc_pkg::DEFAULT_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [psc_pkg::ID_W-1:0]      req_probe_id,
   input  logic                          req_pending,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [psc_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic                          rsp_hit,
   output logic                          rsp_render_now,
   output logic                          rsp_pending_next,
   input  logic                          csr_wr_en,
   input  logic [psc_pkg::BUDGET_W-1:0]  csr_wr_data
);
   import psc_pkg::*;

   psc_cmd_type cmd;
   psc_sts_type sts;

   psc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   psc_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_kind         (req_kind),
      .req_probe_id     (req_probe_id),
      .req_pending      (req_pending),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_hit          (rsp_hit),
      .rsp_render_now   (rsp_render_now),
      .rsp_pending_next (rsp_pending_next),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

endmodule
